@@ rtl/dtns_pkg.sv @@
// ---------------------------------------------------------------------------
// dtns_pkg: shared types and constants for the next-second calendar block
// Beat layout, per-stage payload structs, calendar limits and month table.
// ---------------------------------------------------------------------------
`default_nettype none

package dtns_pkg;

  // One date and time beat
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dtns_beat_t;

  // Time of day only
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dtns_tod_t;

  // Payload after the first stage
  typedef struct packed {
    dtns_beat_t  beat;       // original input
    dtns_tod_t   tod_next;   // time of day plus one second
    logic        day_carry;  // 23:59:59 rollover
    logic        fields_ok;  // all but year and day-vs-month-length in range
    logic        year_ok;
    logic [9:0]  year_q25;   // year / 25
  } dtns_s1_t;

  // Payload after the second stage
  typedef struct packed {
    dtns_beat_t  beat;
    dtns_tod_t   tod_next;
    logic        day_carry;
    logic        fields_ok;
    logic        year_ok;
    logic [4:0]  month_len;  // days in this month of this year, 0 if bad month
  } dtns_s2_t;

  // Result beat
  typedef struct packed {
    dtns_beat_t  beat;
    logic        bad;
  } dtns_res_t;

  // Calendar limits
  localparam logic [5:0]  SEC_MAX       = 6'd59;
  localparam logic [5:0]  MIN_MAX       = 6'd59;
  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;

  // year / 25 == (year * 5243) >> 17, exact for any 14-bit year
  localparam logic [12:0] DIV25_RECIP   = 13'd5243;
  localparam int          DIV25_SHIFT   = 17;

  // Common-year month lengths, January first
  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days in a month; 0 for a month code outside January..December
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = month - MONTH_JAN;
    if (month < MONTH_JAN || month > MONTH_DEC) begin
      len = 5'd0;
    end else if (month == MONTH_FEB && leap) begin
      len = FEB_LEAP_DAYS;
    end else begin
      len = MONTH_LEN[idx];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dtns_time_stage.sv @@
// ---------------------------------------------------------------------------
// dtns_time_stage: first pipeline stage
// Range checks, time-of-day increment with rollover detect, year / 25.
// ---------------------------------------------------------------------------
`default_nettype none

module dtns_time_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_i,
  input  wire dtns_pkg::dtns_beat_t data_i,
  output logic                     valid_r,
  output dtns_pkg::dtns_s1_t       data_r
);
  import dtns_pkg::*;

  dtns_s1_t    data_nxt;
  logic [26:0] q_prod;
  logic        sec_wrap;
  logic        min_wrap;
  logic        hour_wrap;

  // Second, minute, hour increment chain
  assign sec_wrap  = (data_i.second == SEC_MAX);
  assign min_wrap  = sec_wrap && (data_i.minute == MIN_MAX);
  assign hour_wrap = min_wrap && (data_i.hour == HOUR_MAX);

  // Reciprocal multiply for year / 25
  assign q_prod = 27'(data_i.year) * 27'(DIV25_RECIP);

  always_comb begin
    data_nxt.beat = data_i;
    data_nxt.tod_next.second = sec_wrap ? 6'd0 : data_i.second + 6'd1;
    data_nxt.tod_next.minute = !sec_wrap ? data_i.minute :
                               (min_wrap ? 6'd0 : data_i.minute + 6'd1);
    data_nxt.tod_next.hour   = !min_wrap ? data_i.hour :
                               (hour_wrap ? 5'd0 : data_i.hour + 5'd1);
    data_nxt.day_carry = hour_wrap;
    data_nxt.fields_ok = (data_i.month >= MONTH_JAN) && (data_i.month <= MONTH_DEC) &&
                         (data_i.day != 5'd0) && (data_i.hour <= HOUR_MAX) &&
                         (data_i.minute <= MIN_MAX) && (data_i.second <= SEC_MAX);
    data_nxt.year_ok  = (data_i.year <= YEAR_MAX);
    data_nxt.year_q25 = 10'(q_prod >> DIV25_SHIFT);
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dtns_leap_stage.sv @@
// ---------------------------------------------------------------------------
// dtns_leap_stage: second pipeline stage
// Leap-year test from year / 25 and month length lookup.
// ---------------------------------------------------------------------------
`default_nettype none

module dtns_leap_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire dtns_pkg::dtns_s1_t data_i,
  output logic                   valid_r,
  output dtns_pkg::dtns_s2_t     data_r
);
  import dtns_pkg::*;

  dtns_s2_t    data_nxt;
  logic [13:0] q_times25;
  logic        div25;
  logic        leap;

  // year % 25 == 0 when q*25 gives back the year
  assign q_times25 = 14'({data_i.year_q25, 4'b0}) + 14'({data_i.year_q25, 3'b0}) +
                     14'(data_i.year_q25);
  assign div25 = (q_times25 == data_i.beat.year);

  // Leap: by 4 and not by 100, or by 400 (= by 16 and by 25)
  assign leap = (data_i.beat.year[1:0] == 2'b00) &&
                (!div25 || (data_i.beat.year[3:0] == 4'b0000));

  always_comb begin
    data_nxt.beat      = data_i.beat;
    data_nxt.tod_next  = data_i.tod_next;
    data_nxt.day_carry = data_i.day_carry;
    data_nxt.fields_ok = data_i.fields_ok;
    data_nxt.year_ok   = data_i.year_ok;
    data_nxt.month_len = month_days(data_i.beat.month, leap);
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dtns_date_stage.sv @@
// ---------------------------------------------------------------------------
// dtns_date_stage: third pipeline stage and output register
// Final validity check and day/month/year carry on the midnight rollover.
// ---------------------------------------------------------------------------
`default_nettype none

module dtns_date_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire dtns_pkg::dtns_s2_t data_i,
  output logic                   valid_r,
  output dtns_pkg::dtns_res_t    data_r
);
  import dtns_pkg::*;

  dtns_res_t data_nxt;
  logic      bad;
  logic      month_end;

  assign bad = !data_i.fields_ok || !data_i.year_ok || (data_i.beat.day > data_i.month_len);
  assign month_end = (data_i.beat.day == data_i.month_len);

  // Bad beats pass unchanged; good ones take the new time and maybe a new date
  always_comb begin
    data_nxt.bad  = bad;
    data_nxt.beat = data_i.beat;
    if (!bad) begin
      data_nxt.beat.hour   = data_i.tod_next.hour;
      data_nxt.beat.minute = data_i.tod_next.minute;
      data_nxt.beat.second = data_i.tod_next.second;
      if (data_i.day_carry) begin
        if (!month_end) begin
          data_nxt.beat.day = data_i.beat.day + 5'd1;
        end else if (data_i.beat.month == MONTH_DEC) begin
          data_nxt.beat.day   = 5'd1;
          data_nxt.beat.month = MONTH_JAN;
          data_nxt.beat.year  = (data_i.beat.year == YEAR_MAX) ? 14'd0 :
                                data_i.beat.year + 14'd1;
        end else begin
          data_nxt.beat.day   = 5'd1;
          data_nxt.beat.month = data_i.beat.month + 4'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/date_time_next_second.sv @@
// ---------------------------------------------------------------------------
// date_time_next_second: Gregorian date and time advanced by one second
// Three-stage pipeline: time increment and year / 25, leap and month length,
// date carry and output register.
//
// Input channel in_*: one beat is a full date and time, taken at an edge with
// in_valid high and in_stall low. Result channel out_*: the same moment one
// second later, plus out_bad_input, which flags a date or time out of range;
// such a beat comes back unchanged. One result per input, in order.
// An accepted beat passes the time, leap and date stage registers in turn to
// out_valid; throughput is one beat per cycle while out_stall is low.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out while out_stall is high. in_stall rises only when all
// three stages hold a beat and out_stall is high. A stalled result holds its
// value. Synchronous reset empties the pipeline; payload is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module date_time_next_second (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] in_year_in,
  input  wire logic [3:0]  in_month_in,
  input  wire logic [4:0]  in_day_in,
  input  wire logic [4:0]  in_hour_in,
  input  wire logic [5:0]  in_minute_in,
  input  wire logic [5:0]  in_second_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [13:0]      out_year_out,
  output logic [3:0]       out_month_out,
  output logic [4:0]       out_day_out,
  output logic [4:0]       out_hour_out,
  output logic [5:0]       out_minute_out,
  output logic [5:0]       out_second_out,
  output logic             out_bad_input
);
  import dtns_pkg::*;

  dtns_beat_t in_beat;
  dtns_s1_t   s1_data;
  dtns_s2_t   s2_data;
  dtns_res_t  s3_data;
  logic       s1_valid;
  logic       s2_valid;
  logic       s3_valid;
  logic       s1_en;
  logic       s2_en;
  logic       s3_en;

  // Pack input beat
  assign in_beat.year   = in_year_in;
  assign in_beat.month  = in_month_in;
  assign in_beat.day    = in_day_in;
  assign in_beat.hour   = in_hour_in;
  assign in_beat.minute = in_minute_in;
  assign in_beat.second = in_second_in;

  // Stage load enables: a stage moves when empty or when its successor moves
  assign s3_en    = !s3_valid || !out_stall;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  dtns_time_stage u_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_en),
    .valid_i (in_valid),
    .data_i  (in_beat),
    .valid_r (s1_valid),
    .data_r  (s1_data)
  );

  dtns_leap_stage u_leap (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s2_en),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_r (s2_valid),
    .data_r  (s2_data)
  );

  dtns_date_stage u_date (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s3_en),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_r (s3_valid),
    .data_r  (s3_data)
  );

  // Unpack result beat
  assign out_valid      = s3_valid;
  assign out_year_out   = s3_data.beat.year;
  assign out_month_out  = s3_data.beat.month;
  assign out_day_out    = s3_data.beat.day;
  assign out_hour_out   = s3_data.beat.hour;
  assign out_minute_out = s3_data.beat.minute;
  assign out_second_out = s3_data.beat.second;
  assign out_bad_input  = s3_data.bad;

  // Input only backs up when the whole pipe is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s2_valid && s3_valid && out_stall))
    else $error("in_stall with a free pipeline slot");

  // A good result carries an in-range time of day
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_input) |->
      (out_second_out <= SEC_MAX && out_minute_out <= MIN_MAX && out_hour_out <= HOUR_MAX))
    else $error("good result with time of day out of range");

  // A good result carries an in-range date
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_input) |->
      (out_month_out >= MONTH_JAN && out_month_out <= MONTH_DEC &&
       out_day_out != 5'd0 && out_year_out <= YEAR_MAX))
    else $error("good result with date out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid && !s2_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
